// ===== rtl/core/lrbs_pkg.sv =====
package lrbs_pkg;

    // op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RETRY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REBOOT_AFTER  = 2'd3;

    localparam int unsigned CFG_DATA_W = 32;

    // reset values of the configuration registers
    localparam logic [19:0] INITIAL_RETRY_RST = 20'd1000;
    localparam logic [23:0] MAX_RETRY_RST     = 24'd60000;
    localparam logic [15:0] SETTLE_RST        = 16'd200;
    localparam logic [31:0] REBOOT_AFTER_RST  = 32'd600000;

    // retry delay never exceeds max(initial, max), both below 2^24
    localparam int unsigned DELAY_W = 24;

    typedef struct packed {
        logic [19:0] initial_retry_ms;
        logic [23:0] max_retry_ms;
        logic [15:0] settle_ms;
        logic [31:0] reboot_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic        link_connected;
    } t_in;

    typedef struct packed {
        logic        link_up;
        logic        issue_begin;
        logic        issue_disconnect;
        logic        request_reboot;
        logic [15:0] attempt_count;
        logic [31:0] connected_since;
        logic [31:0] disconnected_ms;
    } t_out;

endpackage

// ===== rtl/core/link_reconnect_backoff_supervisor.sv =====
// Path: input register, then step logic into the result register.
// Throughput: one item per cycle while i_out_ready does not stall the result
//   register; the supervisor state updates in the same cycle the registered
//   item moves to the result register.
// Reset (i_rst_n, synchronous, active low): state cleared, config registers
//   load their defaults, both pipeline stages empty.
module link_reconnect_backoff_supervisor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [lrbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lrbs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lrbs_pkg::t_in                   i_in_data,
    // results
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lrbs_pkg::t_out                  o_out_data
);
    import lrbs_pkg::*;

    t_cfg cfg;
    t_out res;

    // stage 1: input register
    logic r_in_valid;
    t_in  r_in_data;
    // stage 2: result register
    logic r_out_valid;
    t_out r_out_data;

    logic out_load;   // result register can take a new item this cycle
    logic step;       // registered item is processed and leaves stage 1
    logic in_xfer;    // input transfer

    assign out_load   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_load;
    assign o_in_ready = !r_in_valid || out_load;
    assign in_xfer    = i_in_valid && o_in_ready;

    lrbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // State machine of the supervisor: commits only on a step, so a stalled
    // item in stage 1 sees the same state until it moves.
    lrbs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_item  (r_in_data),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_data <= i_in_data;
        end
        if (step) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a connect and a disconnect request never share one result
    a_begin_disc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.issue_begin && o_out_data.issue_disconnect))
        else $error("connect and disconnect requested together");

    // a reboot request ends the step: no connect or disconnect with it
    a_reboot_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.request_reboot)
            |-> !(o_out_data.issue_begin || o_out_data.issue_disconnect
                  || o_out_data.link_up))
        else $error("reboot request combined with other actions");

    // down time reads zero whenever the link is reported up
    a_up_no_downtime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.link_up) |-> (o_out_data.disconnected_ms == 32'd0))
        else $error("nonzero down time while link up");

    // a result moves to the output only from a filled input stage
    a_step_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && out_load) |=> !o_out_valid)
        else $error("result produced without an item");

endmodule

// ===== rtl/core/lrbs_cfg.sv =====
module lrbs_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lrbs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output lrbs_pkg::t_cfg                  o_cfg
);
    import lrbs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INITIAL_RETRY: n_cfg.initial_retry_ms = i_cfg_wdata[19:0];
                REG_MAX_RETRY:     n_cfg.max_retry_ms     = i_cfg_wdata[23:0];
                REG_SETTLE:        n_cfg.settle_ms        = i_cfg_wdata[15:0];
                REG_REBOOT_AFTER:  n_cfg.reboot_limit_ms  = i_cfg_wdata[31:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_retry_ms <= INITIAL_RETRY_RST;
            r_cfg.max_retry_ms     <= MAX_RETRY_RST;
            r_cfg.settle_ms        <= SETTLE_RST;
            r_cfg.reboot_limit_ms  <= REBOOT_AFTER_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/lrbs_core.sv =====
module lrbs_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lrbs_pkg::t_cfg i_cfg,
    input  logic           i_step,
    input  lrbs_pkg::t_in  i_item,
    output lrbs_pkg::t_out o_res
);
    import lrbs_pkg::*;

    logic               r_started, n_started;
    logic               r_was_up, n_was_up;
    logic               r_settle_pending, n_settle_pending;
    logic               r_down_valid, n_down_valid;
    logic               r_ever_up, n_ever_up;
    logic [31:0]        r_up_ts, n_up_ts;
    logic [31:0]        r_down_ts, n_down_ts;
    logic [31:0]        r_last_try, n_last_try;
    logic [DELAY_W-1:0] r_retry_delay, n_retry_delay;
    logic [15:0]        r_retry_count, n_retry_count;

    logic [31:0]        now;
    logic [31:0]        since_try;
    logic [31:0]        down_ts_pre;
    logic [31:0]        since_down;
    logic [DELAY_W:0]   dbl;
    logic [DELAY_W:0]   dbl_hi;
    logic [DELAY_W:0]   init_ext;
    logic               up, begin_req, disc, reboot;

    assign now       = i_item.now_ms;
    assign since_try = now - r_last_try;
    // down edge or missing down mark restarts the down clock this step
    assign down_ts_pre = (r_was_up || !r_down_valid) ? now : r_down_ts;
    assign since_down  = now - down_ts_pre;
    assign dbl         = {r_retry_delay, 1'b0};
    assign init_ext    = {{(DELAY_W + 1 - 20){1'b0}}, i_cfg.initial_retry_ms};
    // clamp above by max first, then below by initial
    assign dbl_hi = (dbl > {1'b0, i_cfg.max_retry_ms}) ? {1'b0, i_cfg.max_retry_ms} : dbl;

    always_comb begin
        n_started        = r_started;
        n_was_up         = r_was_up;
        n_settle_pending = r_settle_pending;
        n_down_valid     = r_down_valid;
        n_ever_up        = r_ever_up;
        n_up_ts          = r_up_ts;
        n_down_ts        = r_down_ts;
        n_last_try       = r_last_try;
        n_retry_delay    = r_retry_delay;
        n_retry_count    = r_retry_count;
        up        = 1'b0;
        begin_req = 1'b0;
        disc      = 1'b0;
        reboot    = 1'b0;

        if (i_item.op == OP_START) begin
            if (!r_started) begin
                n_started     = 1'b1;
                begin_req     = 1'b1;
                n_last_try    = now;
                n_down_ts     = now;
                n_down_valid  = 1'b1;
                n_retry_delay = init_ext[DELAY_W-1:0];
                n_retry_count = '0;
            end
        end else if (i_item.link_connected) begin
            up = 1'b1;
            if (!r_was_up) begin
                n_was_up         = 1'b1;
                n_ever_up        = 1'b1;
                n_up_ts          = now;
                n_down_valid     = 1'b0;
                n_settle_pending = 1'b0;
                n_retry_count    = '0;
                n_retry_delay    = init_ext[DELAY_W-1:0];
            end
        end else begin
            n_was_up     = 1'b0;
            n_down_ts    = down_ts_pre;
            n_down_valid = 1'b1;
            if (r_settle_pending) begin
                if (since_try >= {16'd0, i_cfg.settle_ms}) begin
                    n_settle_pending = 1'b0;
                    begin_req        = 1'b1;
                    n_last_try       = now;
                end
            end else if (r_ever_up && (since_down > i_cfg.reboot_limit_ms)) begin
                reboot = 1'b1;
            end else if (since_try >= {{(32 - DELAY_W){1'b0}}, r_retry_delay}) begin
                n_last_try       = now;
                n_retry_count    = r_retry_count + 16'd1;
                disc             = 1'b1;
                n_settle_pending = 1'b1;
                n_retry_delay    = (dbl_hi < init_ext) ? init_ext[DELAY_W-1:0]
                                                       : dbl_hi[DELAY_W-1:0];
            end
        end
    end

    always_comb begin
        o_res.link_up          = up;
        o_res.issue_begin      = begin_req;
        o_res.issue_disconnect = disc;
        o_res.request_reboot   = reboot;
        o_res.attempt_count    = n_retry_count;
        o_res.connected_since  = n_up_ts;
        o_res.disconnected_ms  = (i_item.link_connected || !n_down_valid) ? 32'd0
                                                                          : now - n_down_ts;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started        <= 1'b0;
            r_was_up         <= 1'b0;
            r_settle_pending <= 1'b0;
            r_down_valid     <= 1'b0;
            r_ever_up        <= 1'b0;
            r_up_ts          <= '0;
            r_down_ts        <= '0;
            r_last_try       <= '0;
            r_retry_delay    <= {{(DELAY_W - 20){1'b0}}, INITIAL_RETRY_RST};
            r_retry_count    <= '0;
        end else if (i_step) begin
            r_started        <= n_started;
            r_was_up         <= n_was_up;
            r_settle_pending <= n_settle_pending;
            r_down_valid     <= n_down_valid;
            r_ever_up        <= n_ever_up;
            r_up_ts          <= n_up_ts;
            r_down_ts        <= n_down_ts;
            r_last_try       <= n_last_try;
            r_retry_delay    <= n_retry_delay;
            r_retry_count    <= n_retry_count;
        end
    end

endmodule
